[design/ipc_pkg.sv]
// Package for the integer partition counter.
// Holds status codes, field widths and the term control type.
// No dependencies.
package ipc_pkg;

  // Width of the request field
  localparam int N_W = 10;

  // Width of the status field
  localparam int STATUS_W = 2;

  // Guard bits on top of the value width in the signed accumulator
  localparam int ACC_GUARD = 9;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_POSITIVE = 2'd3;

  // One recurrence term, issued alongside its table read
  typedef struct packed {
    logic valid;  // term contributes
    logic one;    // offset equals m: contributes 1, no table read
    logic neg;    // even k: subtract
  } ipc_term_t;

endpackage

[design/ipc_table.sv]
// Partition table memory: entry i holds p(i+1) and its saturation mark.
// One write port, one registered read port; p(1) and p(2) are fixed values.
// Depends on nothing outside this file.
module ipc_table #(
  parameter int MAX_N      = 512,
  parameter int VALUE_BITS = 64
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(MAX_N)-1:0]   rd_idx,
  output logic [VALUE_BITS-1:0]      rd_value,
  output logic                       rd_mark,
  input  logic                       wr_en,
  input  logic [$clog2(MAX_N)-1:0]   wr_idx,
  input  logic [VALUE_BITS-1:0]      wr_value,
  input  logic                       wr_mark
);

  localparam int IDX_W = $clog2(MAX_N);

  logic [VALUE_BITS:0] mem [MAX_N];
  logic [VALUE_BITS:0] rd_data_r;
  logic                preset_r;
  logic                first_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_mark, wr_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
      preset_r  <= (rd_idx < IDX_W'(2));
      first_r   <= (rd_idx == '0);
    end
  end

  // p(1) = 1 and p(2) = 2 are never written
  always_comb begin
    if (preset_r) begin
      rd_value = first_r ? VALUE_BITS'(1) : VALUE_BITS'(2);
      rd_mark  = 1'b0;
    end else begin
      rd_value = rd_data_r[VALUE_BITS-1:0];
      rd_mark  = rd_data_r[VALUE_BITS];
    end
  end

endmodule

[design/ipc_accum.sv]
// Signed accumulator for the pentagonal recurrence of one table entry.
// Registers each issued term so it lines up with its table read data in the next cycle.
// Depends on ipc_pkg.
module ipc_accum #(
  parameter int VALUE_BITS = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    clear,
  input  ipc_pkg::ipc_term_t                      term,
  input  logic [VALUE_BITS-1:0]                   rd_value,
  input  logic                                    rd_mark,
  output logic [VALUE_BITS+ipc_pkg::ACC_GUARD-1:0] acc,
  output logic                                    marked
);

  localparam int ACC_W = VALUE_BITS + ipc_pkg::ACC_GUARD;

  ipc_pkg::ipc_term_t term_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;
  logic               marked_r;
  logic [ACC_W-1:0]   addend;

  always_comb begin
    addend  = term_r.one ? ACC_W'(1) : ACC_W'(rd_value);
    acc_nxt = term_r.neg ? (acc_r - addend) : (acc_r + addend);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      term_r   <= '0;
      acc_r    <= '0;
      marked_r <= 1'b0;
    end else begin
      term_r <= term;
      if (term_r.valid) begin
        acc_r <= acc_nxt;
        if (!term_r.one && rd_mark) begin
          marked_r <= 1'b1;
        end
      end
    end
  end

  assign acc    = acc_r;
  assign marked = marked_r;

endmodule

[design/integer_partition_count.sv]
// Integer partition counter: answers p(n) for a request n.
// Channels: a request transfer on in_valid/in_ready carries in_n_requested;
// a result transfer on out_valid/out_ready carries out_partition_count and
// out_status (ok, out of range, overflow, sum not positive).
// Requests of 0, 1 or 2 return n; requests above MAX_N return 0, out of range.
// Otherwise p(n) comes from a table memory holding p(1) up to the highest n
// computed so far; a request beyond that point first extends the table one
// entry at a time by Euler's pentagonal recurrence.
//
// A small or out-of-range request is set into the result register at its
// transfer and goes from there to the output register; a request already
// in the table first passes through a table read (S_READ, then S_RDATA).
// Each new table entry m is built by issuing one recurrence term per cycle
// through the single read port of the table, the pair of offsets of each k
// with k(3k-1)/2 <= m (about sqrt(2m/3) such k); then the walk stops and
// the entry is written back. One request is handled at a time; the next
// request is taken once the previous result has moved into the output register.
// Reset: the table holds p(1) and p(2) only; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next request
// is accepted and worked on, but its result waits until that register is free.
module integer_partition_count #(
  parameter int MAX_N      = 512,
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ipc_pkg::N_W-1:0]       in_n_requested,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VALUE_BITS-1:0]         out_partition_count,
  output logic [ipc_pkg::STATUS_W-1:0]  out_status
);

  localparam int N_W   = ipc_pkg::N_W;
  localparam int CNT_W = $clog2(MAX_N + 1);
  localparam int LIM_W = (CNT_W > N_W) ? CNT_W : N_W;
  localparam int OFF_W = LIM_W + 1;
  localparam int IDX_W = $clog2(MAX_N);
  localparam int ACC_W = VALUE_BITS + ipc_pkg::ACC_GUARD;
  localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_FINISH = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_RDATA  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]       state_r;
  logic [LIM_W-1:0] n_r;        // request being served
  logic [LIM_W-1:0] m_r;        // table entry being computed
  logic [LIM_W-1:0] filled_r;   // highest n held in the table
  logic [LIM_W-1:0] k_r;        // pentagonal index
  logic [OFF_W-1:0] km_r;       // k(3k-1)/2
  logic             sel_r;      // second offset of the pair, k(3k+1)/2

  logic [VALUE_BITS-1:0]         res_count_r;
  logic [ipc_pkg::STATUS_W-1:0]  res_status_r;
  logic                          out_valid_r;
  logic [VALUE_BITS-1:0]         out_count_r;
  logic [ipc_pkg::STATUS_W-1:0]  out_status_r;

  // Table and accumulator connections
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_idx;
  logic [VALUE_BITS-1:0]   rd_value;
  logic                    rd_mark;
  logic                    wr_en;
  logic [VALUE_BITS-1:0]   wr_value;
  logic                    wr_mark;
  ipc_pkg::ipc_term_t      term;
  logic                    acc_clear;
  logic [ACC_W-1:0]        acc;
  logic                    marked;

  // Walk and finish decode
  logic [LIM_W-1:0] n_in;
  logic [OFF_W-1:0] m_off;
  logic [OFF_W-1:0] off;
  logic [OFF_W-1:0] idx_full;
  logic             walk_stop;
  logic             not_pos;
  logic             too_big;
  logic             sat;
  logic             in_fire;
  logic             out_load;

  assign n_in      = LIM_W'(in_n_requested);
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign m_off     = OFF_W'(m_r);
  assign off       = sel_r ? (km_r + OFF_W'(k_r)) : km_r;
  assign walk_stop = (km_r > m_off);
  assign idx_full  = m_off - off - OFF_W'(1);

  // Issue one term per walk cycle; offsets beyond m contribute nothing
  always_comb begin
    term       = '0;
    term.valid = (state_r == S_WALK) && !walk_stop && (off <= m_off);
    term.one   = (off == m_off);
    term.neg   = !k_r[0];
    rd_en      = 1'b0;
    rd_idx     = idx_full[IDX_W-1:0];
    unique case (state_r)
      S_WALK: rd_en = term.valid && !term.one;
      S_READ: begin
        rd_en  = 1'b1;
        rd_idx = IDX_W'(n_r - LIM_W'(1));
      end
      default: rd_en = 1'b0;
    endcase
  end

  assign acc_clear = (state_r == S_IDLE) || (state_r == S_FINISH);

  assign not_pos = acc[ACC_W-1] || (acc == '0);
  assign too_big = |acc[ACC_W-1:VALUE_BITS];
  assign sat     = marked || too_big;

  assign wr_en    = (state_r == S_FINISH) && (marked || !not_pos);
  assign wr_mark  = sat;
  assign wr_value = sat ? VALUE_MASK : acc[VALUE_BITS-1:0];

  ipc_table #(
    .MAX_N      (MAX_N),
    .VALUE_BITS (VALUE_BITS)
  ) u_table (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_value (rd_value),
    .rd_mark  (rd_mark),
    .wr_en    (wr_en),
    .wr_idx   (IDX_W'(m_r - LIM_W'(1))),
    .wr_value (wr_value),
    .wr_mark  (wr_mark)
  );

  ipc_accum #(
    .VALUE_BITS (VALUE_BITS)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (acc_clear),
    .term     (term),
    .rd_value (rd_value),
    .rd_mark  (rd_mark),
    .acc      (acc),
    .marked   (marked)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      filled_r <= LIM_W'(2);
      k_r      <= LIM_W'(1);
      km_r     <= OFF_W'(1);
      sel_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            n_r   <= n_in;
            m_r   <= filled_r + LIM_W'(1);
            k_r   <= LIM_W'(1);
            km_r  <= OFF_W'(1);
            sel_r <= 1'b0;
            priority if (n_in <= LIM_W'(2)) begin
              res_count_r  <= VALUE_BITS'(n_in);
              res_status_r <= ipc_pkg::ST_OK;
              state_r      <= S_DONE;
            end else if (n_in > LIM_W'(MAX_N)) begin
              res_count_r  <= '0;
              res_status_r <= ipc_pkg::ST_RANGE;
              state_r      <= S_DONE;
            end else if (filled_r >= n_in) begin
              state_r <= S_READ;
            end else begin
              state_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          // Advance through the offset pairs; the last term lands as we leave
          if (walk_stop) begin
            state_r <= S_FINISH;
          end else if (!sel_r) begin
            sel_r <= 1'b1;
          end else begin
            sel_r <= 1'b0;
            km_r  <= km_r + (OFF_W'(k_r) << 1) + OFF_W'(k_r) + OFF_W'(1);
            k_r   <= k_r + LIM_W'(1);
          end
        end
        S_FINISH: begin
          if (!marked && not_pos) begin
            // Drop the extension; the table keeps its last good entry
            res_count_r  <= '0;
            res_status_r <= ipc_pkg::ST_NOT_POSITIVE;
            state_r      <= S_DONE;
          end else begin
            filled_r <= m_r;
            if (m_r == n_r) begin
              res_count_r  <= wr_value;
              res_status_r <= sat ? ipc_pkg::ST_OVERFLOW : ipc_pkg::ST_OK;
              state_r      <= S_DONE;
            end else begin
              m_r     <= m_r + LIM_W'(1);
              k_r     <= LIM_W'(1);
              km_r    <= OFF_W'(1);
              sel_r   <= 1'b0;
              state_r <= S_WALK;
            end
          end
        end
        S_READ: state_r <= S_RDATA;
        S_RDATA: begin
          res_count_r  <= rd_mark ? VALUE_MASK : rd_value;
          res_status_r <= rd_mark ? ipc_pkg::ST_OVERFLOW : ipc_pkg::ST_OK;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r  <= res_count_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_partition_count = out_count_r;
  assign out_status          = out_status_r;

endmodule

[design/ipc_checker.sv]
// Port-level checks for the integer partition counter, bound to the top level.
// Depends on ipc_pkg and integer_partition_count.
module ipc_checker #(
  parameter int VALUE_BITS = 64
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [VALUE_BITS-1:0]         out_partition_count,
  input logic [ipc_pkg::STATUS_W-1:0]  out_status
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_partition_count)
      && $stable(out_status))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One request at a time: a request transfer drops in_ready
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // Failed requests report zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ipc_pkg::ST_RANGE
      || out_status == ipc_pkg::ST_NOT_POSITIVE) |-> out_partition_count == '0)
    else $error("failed request with nonzero count");

  // Overflow saturates to all ones
  a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ipc_pkg::ST_OVERFLOW |-> &out_partition_count)
    else $error("overflow result not saturated");

endmodule

bind integer_partition_count ipc_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_ipc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_partition_count (out_partition_count),
  .out_status          (out_status)
);

[tb/integer_partition_count_test.sv]
`timescale 1ns / 1ps
// Self-checking test of integer_partition_count: drives requests, predicts p(n),
// checks results. Depends on ipc_pkg and integer_partition_count only.
module integer_partition_count_test;

  localparam int N_W          = ipc_pkg::N_W;
  localparam int STATUS_W     = ipc_pkg::STATUS_W;
  localparam int MAX_N        = 512;
  localparam int VALUE_BITS   = 64;
  // Extra headroom above the value width so the added and subtracted recurrence sums cannot wrap
  localparam int ACC_W        = VALUE_BITS + 16;
  localparam int N_TOP        = (1 << N_W) - 1;
  localparam int LONG_HOLD    = 200;
  localparam int SETTLE       = 40;
  // The slowest correct run fills the whole table and stalls a few
  // hundred requests on both sides; this bound is many times that.
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [VALUE_BITS-1:0] count;
    logic [STATUS_W-1:0]   status;
  } partition_answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [N_W-1:0]        in_n_requested = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VALUE_BITS-1:0] out_partition_count;
  logic [STATUS_W-1:0]   out_status;

  // Predictor state: p_value[i] holds p(i) for i up to p_known_to
  logic [VALUE_BITS-1:0] p_value [1:MAX_N];
  bit                    p_saturated [1:MAX_N];
  int unsigned           p_known_to;

  partition_answer_t     expected_answers[$];
  int unsigned           error_count = 0;
  int unsigned           cycle_count = 0;
  // Set by the test sequence; both sides idle in random bursts while it is high
  bit                    idling_on = 1'b0;
  // A long receiver hold-off is asked for by bumping hold_asked
  int unsigned           hold_asked = 0;
  int unsigned           hold_done = 0;

  integer_partition_count #(
    .MAX_N      (MAX_N),
    .VALUE_BITS (VALUE_BITS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_n_requested      (in_n_requested),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_partition_count (out_partition_count),
    .out_status          (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // One pentagonal term for p(m): nothing past m, 1 at m, else a table entry.
  // Flag the sum as tainted when the entry used is saturated.
  function automatic logic [ACC_W-1:0] pentagonal_term(input int unsigned m,
                                                       input int unsigned off,
                                                       inout bit tainted);
    if (off > m) return '0;
    if (off == m) return ACC_W'(1);
    if (p_saturated[m - off]) tainted = 1'b1;
    return ACC_W'(p_value[m - off]);
  endfunction

  // Work out p(m) from the entries below it; return 0 when the sum is not positive
  function automatic bit extend_partition_table(input int unsigned m);
    logic [ACC_W-1:0] added;
    logic [ACC_W-1:0] taken;
    logic [ACC_W-1:0] diff;
    bit               tainted;
    int unsigned      k;
    int unsigned      km;
    int unsigned      kp;
    added   = '0;
    taken   = '0;
    tainted = 1'b0;
    k       = 1;
    km      = 1;
    // Odd k adds its pair of terms, even k subtracts them
    while (km <= m) begin
      kp = k * (3 * k + 1) / 2;
      if (k % 2 == 1) begin
        added = added + pentagonal_term(m, km, tainted);
        added = added + pentagonal_term(m, kp, tainted);
      end else begin
        taken = taken + pentagonal_term(m, km, tainted);
        taken = taken + pentagonal_term(m, kp, tainted);
      end
      k  = k + 1;
      km = k * (3 * k - 1) / 2;
    end
    if (tainted) begin
      p_value[m]     = '1;
      p_saturated[m] = 1'b1;
      return 1'b1;
    end
    if (taken >= added) return 1'b0;
    diff = added - taken;
    if (diff[ACC_W-1:VALUE_BITS] != '0) begin
      p_value[m]     = '1;
      p_saturated[m] = 1'b1;
    end else begin
      p_value[m]     = diff[VALUE_BITS-1:0];
      p_saturated[m] = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic partition_answer_t predict_partition(input int unsigned n);
    partition_answer_t answer;
    if (n <= 2) begin
      answer.count  = VALUE_BITS'(n);
      answer.status = ipc_pkg::ST_OK;
      return answer;
    end
    if (n > MAX_N) begin
      answer.count  = '0;
      answer.status = ipc_pkg::ST_RANGE;
      return answer;
    end
    // Grow the table one entry at a time up to n; a bad sum leaves it where it stopped
    while (p_known_to < n) begin
      if (!extend_partition_table(p_known_to + 1)) begin
        answer.count  = '0;
        answer.status = ipc_pkg::ST_NOT_POSITIVE;
        return answer;
      end
      p_known_to = p_known_to + 1;
    end
    if (p_saturated[n]) begin
      answer.count  = '1;
      answer.status = ipc_pkg::ST_OVERFLOW;
    end else begin
      answer.count  = p_value[n];
      answer.status = ipc_pkg::ST_OK;
    end
    return answer;
  endfunction

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------

  // Offer one request and hold it until the transfer; then maybe drop valid for a burst
  task automatic send_request(input logic [N_W-1:0] n);
    partition_answer_t answer;
    in_valid       <= 1'b1;
    in_n_requested <= n;
    do @(posedge clk); while (!in_ready);
    answer           = predict_partition(n);
    expected_answers = {expected_answers, answer};
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result so far has been transferred
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [N_W-1:0] random_request();
    case ($urandom_range(0, 19))
      0:       return N_W'($urandom_range(0, 2));
      1, 2:    return N_W'($urandom_range(MAX_N + 1, N_TOP));
      3:       return N_W'($urandom_range(400, MAX_N));
      default: return N_W'($urandom_range(3, MAX_N));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  // Receiver: ready most of the time, random stall bursts while idling is on,
  // and a long hold-off whenever the sequence asks for one.
  initial begin : result_sink
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    partition_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result: out_partition_count %0d, out_status %0d",
               out_partition_count, out_status);
        error_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_partition_count !== want.count) begin
          $error("out_partition_count: expected %0d, actual %0d",
                 want.count, out_partition_count);
          error_count++;
        end
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, actual %0d", want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Trivial answers for 0..2, then single-step growth from the preset table, a repeat hit and a two-entry jump
  task automatic test_small_requests();
    send_request(N_W'(0));
    send_request(N_W'(1));
    send_request(N_W'(2));
    send_request(N_W'(3));
    send_request(N_W'(4));
    send_request(N_W'(5));
    send_request(N_W'(3));
    send_request(N_W'(7));
  endtask

  // Requests past MAX_N, all request bits high among them; the table must stay put
  task automatic test_out_of_range();
    send_request(N_W'(MAX_N + 1));
    send_request(N_W'(N_TOP));
    send_request(N_W'(768));
    send_request(N_W'(682));
  endtask

  // One long jump, then climb to the top in random strides so each request grows the table
  task automatic test_table_growth();
    int unsigned n;
    send_request(N_W'(100));
    idling_on = 1'b1;
    n = 101;
    while (n < MAX_N) begin
      send_request(N_W'(n));
      n = n + $urandom_range(1, 16);
    end
    idling_on = 1'b0;
  endtask

  // Around the point where p(n) no longer fits in the value width, and the very top
  task automatic test_overflow_region();
    send_request(N_W'(405));
    send_request(N_W'(414));
    send_request(N_W'(415));
    send_request(N_W'(416));
    send_request(N_W'(417));
    send_request(N_W'(420));
    send_request(N_W'(MAX_N - 1));
    send_request(N_W'(MAX_N));
    send_request(N_W'(416));
  endtask

  // Hold the receiver off while requests keep coming, so the block stalls its input
  task automatic test_backpressure();
    idling_on  = 1'b0;
    hold_asked = hold_asked + 1;
    repeat (12) send_request(random_request());
  endtask

  // Pause the sender until everything has come back, then resume
  task automatic test_drain_pause();
    idling_on = 1'b1;
    drain_results();
    repeat (8) send_request(random_request());
  endtask

  // Random requests in chunks, idling switched on for most chunks
  task automatic test_random_requests();
    repeat (5) begin
      idling_on = ($urandom_range(0, 3) != 0);
      repeat (40) send_request(random_request());
    end
  endtask

  // Back-to-back transfers with no idling on either side
  task automatic test_steady_stream();
    idling_on = 1'b0;
    repeat (30) send_request(random_request());
  endtask

  initial begin
    // Predictor reset: only p(1) and p(2) are known
    for (int i = 1; i <= MAX_N; i++) begin
      p_value[i]     = '0;
      p_saturated[i] = 1'b0;
    end
    p_value[1] = VALUE_BITS'(1);
    p_value[2] = VALUE_BITS'(2);
    p_known_to = 2;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_requests();
    test_out_of_range();
    test_table_growth();
    test_overflow_region();
    test_random_requests();
    test_backpressure();
    test_drain_pause();
    test_steady_stream();

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[integer_partition_count.f]
design/ipc_pkg.sv
design/ipc_table.sv
design/ipc_accum.sv
design/integer_partition_count.sv
design/ipc_checker.sv
tb/integer_partition_count_test.sv
